>>> rtl/buddy_page_allocator_defines.svh
// Assertion macros for the buddy page allocator checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// check a property outside reset
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define BPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bpa_pkg.sv
// Types and constants of the buddy page allocator.
// No dependencies.
package bpa_pkg;

  localparam int WORD_W  = 32;
  localparam int WORD_BW = 5;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_START,
    S_AL_RD,
    S_AL_CHK,
    S_SP_RD,
    S_SP_WR,
    S_FR_RD,
    S_FR_CHK,
    S_AD_FIT,
    S_AD_RD,
    S_AD_WR,
    S_DONE
  } state_t;

endpackage

>>> rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/buddy_page_allocator.sv
// Buddy page allocator: sequencer around one free-mark word RAM.
// Depends on bpa_pkg and bpa_ram.
//
// Input channel in_* (valid/ready) takes one beat per request: action,
// order, page, end_page. Output channel out_* gives one beat per request:
// granted and block_page. in_ready is high only while the sequencer idles.
// Free marks live in 32-bit words, one region of words per order; each
// RAM step reads one word, then modifies and writes it back where needed.
// Steps per request:
//   alloc: a read and a check per word scanned over the searched
//          orders, a read and a write per split level, plus start and result.
//   free:  a read and a check per order visited, the order of the
//          block included, plus start and result.
//   add:   per block marked, a fit check per order tried down from
//          MAX_ORDER, then a read and a write; plus start and result.
// After reset a clearing pass writes every RAM word to zero, one word a
// cycle, over (MAX_ORDER+1 rounded up to a power of two) times the word
// count rounded likewise words, 2048 at the defaults; in_ready stays low.
// A result that the receiver stalls is held in the output register; the
// next request is accepted meanwhile and its own result waits behind it.
module buddy_page_allocator #(
  parameter int MAX_ORDER = 10,
  parameter int NUM_PAGES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_order,
  input  logic [11:0] in_page,
  input  logic [12:0] in_end_page,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_granted,
  output logic [11:0] out_block_page
);
  import bpa_pkg::*;

  localparam int PGA   = $clog2(NUM_PAGES) + 1;
  localparam int PGB   = (PGA > 13) ? PGA : 13;
  localparam int PGW   = (PGB > MAX_ORDER + 2) ? PGB : MAX_ORDER + 2;
  localparam int KW    = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ADW   = KW + WIW;
  localparam int DEPTH = 1 << ADW;

  localparam logic [PGW-1:0] NP_C  = PGW'(NUM_PAGES);
  localparam logic [KW-1:0]  MAXK  = KW'(MAX_ORDER);
  localparam logic [4:0]     MAXO5 = 5'(MAX_ORDER);

  state_t state_r, state_nxt;
  logic [ADW-1:0]    clr_r, clr_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [WIW-1:0]    w_r, w_nxt;
  logic [PGW-1:0]    idx_r, idx_nxt;
  logic [PGW-1:0]    p_r, p_nxt;
  logic [PGW-1:0]    e_r, e_nxt;
  logic              first_r, first_nxt;
  logic [1:0]        act_r, act_nxt;
  logic [3:0]        ord_r, ord_nxt;
  logic [11:0]       pg_r, pg_nxt;
  logic [12:0]       endp_r, endp_nxt;
  logic              gnt_r, gnt_nxt;
  logic [11:0]       res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_granted_r, out_granted_nxt;
  logic [11:0]       out_page_r, out_page_nxt;

  logic              ram_we;
  logic [ADW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, rdata;

  logic [PGW-1:0]     blocks_k, nw_k, size_k, pmask, fidx, eclamp, idx_ext;
  logic               last_w, k_is_ord, aligned, fits;
  logic [WORD_W-1:0]  lsb, oh_b, oh_bud, oh_sp, fr_word;
  logic [WORD_BW-1:0] pos, b_sel;
  logic [ADW-1:0]     idx_addr;

  bpa_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    blocks_k = NP_C >> k_r;
    nw_k     = (blocks_k + PGW'(WORD_W - 1)) >> WORD_BW;
    last_w   = (PGW'(w_r) + PGW'(1)) >= nw_k;
    k_is_ord = (5'(k_r) == 5'(ord_r));
    size_k   = PGW'(1) << k_r;
    aligned  = (p_r & (size_k - PGW'(1))) == '0;
    fits     = (p_r + size_k) <= e_r;
    pmask    = (PGW'(1) << ord_r) - PGW'(1);
    fidx     = PGW'(pg_r) >> ord_r;
    eclamp   = (PGW'(endp_r) > NP_C) ? NP_C : PGW'(endp_r);
    b_sel    = idx_r[WORD_BW-1:0];
    oh_b     = WORD_W'(1) << b_sel;
    oh_bud   = WORD_W'(1) << (b_sel ^ WORD_BW'(1));
    oh_sp    = WORD_W'(1) << (b_sel | WORD_BW'(1));
    fr_word  = rdata | oh_b;
    idx_addr = {k_r, idx_r[WIW+WORD_BW-1:WORD_BW]};
    lsb      = rdata & (~rdata + WORD_W'(1));
    for (int j = 0; j < WORD_BW; j++) begin
      pos[j] = 1'b0;
      for (int i = 0; i < WORD_W; i++) begin
        if (((i >> j) & 1) == 1) begin
          pos[j] = pos[j] | lsb[i];
        end
      end
    end
    idx_ext = PGW'({w_r, pos});
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    k_nxt           = k_r;
    w_nxt           = w_r;
    idx_nxt         = idx_r;
    p_nxt           = p_r;
    e_nxt           = e_r;
    first_nxt       = first_r;
    act_nxt         = act_r;
    ord_nxt         = ord_r;
    pg_nxt          = pg_r;
    endp_nxt        = endp_r;
    gnt_nxt         = gnt_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_granted_nxt = out_granted_r;
    out_page_nxt    = out_page_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + ADW'(1);
        if (clr_r == {ADW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          ord_nxt   = in_order;
          pg_nxt    = in_page;
          endp_nxt  = in_end_page;
          state_nxt = S_START;
        end
      end
      S_START: begin
        gnt_nxt   = 1'b0;
        res_nxt   = '0;
        first_nxt = 1'b1;
        state_nxt = S_DONE;
        unique case (act_r)
          ACT_ALLOC: begin
            if (5'(ord_r) <= MAXO5) begin
              k_nxt     = KW'(ord_r);
              w_nxt     = '0;
              state_nxt = S_AL_RD;
            end
          end
          ACT_FREE: begin
            if ((5'(ord_r) <= MAXO5) && ((PGW'(pg_r) & pmask) == '0) &&
                (fidx < (NP_C >> ord_r))) begin
              k_nxt     = KW'(ord_r);
              idx_nxt   = fidx;
              state_nxt = S_FR_RD;
            end
          end
          ACT_ADD: begin
            if (eclamp > PGW'(pg_r)) begin
              p_nxt     = PGW'(pg_r);
              e_nxt     = eclamp;
              k_nxt     = MAXK;
              state_nxt = S_AD_FIT;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_AL_RD: begin
        state_nxt = S_AL_CHK;
      end
      S_AL_CHK: begin
        if (rdata != '0) begin
          if (k_is_ord) begin
            gnt_nxt   = 1'b1;
            res_nxt   = 12'(idx_ext << ord_r);
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_ext << 1;
            k_nxt     = k_r - KW'(1);
            state_nxt = S_SP_RD;
          end
        end else if (last_w) begin
          if (k_r == MAXK) begin
            state_nxt = S_DONE;
          end else begin
            k_nxt     = k_r + KW'(1);
            w_nxt     = '0;
            state_nxt = S_AL_RD;
          end
        end else begin
          w_nxt     = w_r + WIW'(1);
          state_nxt = S_AL_RD;
        end
      end
      S_SP_RD: begin
        state_nxt = S_SP_WR;
      end
      S_SP_WR: begin
        if (k_is_ord) begin
          gnt_nxt   = 1'b1;
          res_nxt   = 12'(idx_r << ord_r);
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r << 1;
          k_nxt     = k_r - KW'(1);
          state_nxt = S_SP_RD;
        end
      end
      S_FR_RD: begin
        state_nxt = S_FR_CHK;
      end
      S_FR_CHK: begin
        if (first_r && ((rdata & oh_b) != '0)) begin
          state_nxt = S_DONE;
        end else if ((k_r != MAXK) && ((fr_word & oh_bud) != '0)) begin
          idx_nxt   = idx_r >> 1;
          k_nxt     = k_r + KW'(1);
          first_nxt = 1'b0;
          state_nxt = S_FR_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_AD_FIT: begin
        if (aligned && fits) begin
          idx_nxt   = p_r >> k_r;
          state_nxt = S_AD_RD;
        end else begin
          k_nxt = k_r - KW'(1);
        end
      end
      S_AD_RD: begin
        state_nxt = S_AD_WR;
      end
      S_AD_WR: begin
        p_nxt = p_r + size_k;
        k_nxt = MAXK;
        if ((p_r + size_k) < e_r) begin
          state_nxt = S_AD_FIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = gnt_r;
          out_page_nxt    = res_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = idx_addr;
    ram_wdata = rdata;
    ram_raddr = idx_addr;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_AL_RD: begin
        ram_raddr = {k_r, w_r};
      end
      S_AL_CHK: begin
        ram_we    = (rdata != '0);
        ram_waddr = {k_r, w_r};
        ram_wdata = rdata & ~lsb;
      end
      S_SP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rdata | oh_sp;
      end
      S_FR_CHK: begin
        ram_we = !(first_r && ((rdata & oh_b) != '0));
        if ((k_r != MAXK) && ((fr_word & oh_bud) != '0)) begin
          ram_wdata = fr_word & ~oh_b & ~oh_bud;
        end else begin
          ram_wdata = fr_word;
        end
      end
      S_AD_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rdata | oh_b;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    w_r           <= w_nxt;
    idx_r         <= idx_nxt;
    p_r           <= p_nxt;
    e_r           <= e_nxt;
    first_r       <= first_nxt;
    act_r         <= act_nxt;
    ord_r         <= ord_nxt;
    pg_r          <= pg_nxt;
    endp_r        <= endp_nxt;
    gnt_r         <= gnt_nxt;
    res_r         <= res_nxt;
    out_granted_r <= out_granted_nxt;
    out_page_r    <= out_page_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_granted    = out_granted_r;
  assign out_block_page = out_page_r;

endmodule

>>> rtl/bpa_checker.sv
// Port-level checks of the buddy page allocator, bound to the top level.
// Depends on buddy_page_allocator_defines.svh.
`include "buddy_page_allocator_defines.svh"

module bpa_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_granted,
  input logic [11:0] out_block_page
);

  `BPA_ASSERT(a_deny_zero, out_valid && !out_granted |-> out_block_page == 12'd0, "denied beat carries a page")
  `BPA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_block_page) && $stable(out_granted), "stalled result beat changed")
  `BPA_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !in_ready && !out_valid, "busy flags wrong after reset")

endmodule

bind buddy_page_allocator bpa_port_checker u_bpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_granted    (out_granted),
  .out_block_page (out_block_page)
);
